### rtl/core/e2q_pkg.sv
// Package for the Euler-angle to quaternion converter.
// Holds CORDIC constants, the arctangent table and the shared trig_t type. No dependencies.
package e2q_pkg;

  localparam int AngleW = 16;
  localparam int CompW  = 16;
  localparam int CordW  = 34;   // Q2.30 plus headroom
  localparam int PhaseW = 32;
  localparam int AtanEntries = 24;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [CompW:0] trig_t;  // Q15, range -32768..32768

  function automatic logic signed [PhaseW:0] atan_turn(input int idx);
    logic signed [PhaseW:0] r;
    begin
      case (idx)
        0: r = 33'sd536870912;   1: r = 33'sd316933406;
        2: r = 33'sd167458907;   3: r = 33'sd85004756;
        4: r = 33'sd42667331;    5: r = 33'sd21354465;
        6: r = 33'sd10679838;    7: r = 33'sd5340245;
        8: r = 33'sd2670163;     9: r = 33'sd1335087;
        10: r = 33'sd667544;     11: r = 33'sd333772;
        12: r = 33'sd166886;     13: r = 33'sd83443;
        14: r = 33'sd41722;      15: r = 33'sd20861;
        16: r = 33'sd10430;      17: r = 33'sd5215;
        18: r = 33'sd2608;       19: r = 33'sd1304;
        20: r = 33'sd652;        21: r = 33'sd326;
        22: r = 33'sd163;        23: r = 33'sd81;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // phase part from the remainder of mag/45: floor((r*2^22 + 22) / 45), constant table
  function automatic logic [PhaseW-1:0] rem_phase(input logic [5:0] r);
    logic [PhaseW-1:0] v;
    begin
      v = '0;
      for (int k = 0; k < 45; k++)
        if (r == 6'(k)) v = PhaseW'((longint'(k) * 64'sd4194304 + 64'sd22) / 64'sd45);
      return v;
    end
  endfunction

endpackage

### rtl/core/e2q_lane.sv
// One sine/cosine lane: angle to half-angle phase, folding, pipelined CORDIC.
// Depends on e2q_pkg. One item per cycle when en is high.
module e2q_lane #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2q_pkg::AngleW-1:0] angle,
  output e2q_pkg::trig_t                    sin_q15,
  output e2q_pkg::trig_t                    cos_q15
);
  import e2q_pkg::*;

  localparam int NST = (STAGES < AtanEntries) ? STAGES : AtanEntries;
  localparam logic [AngleW:0] Recip45 = 17'd93207;  // ceil(2^22/45)

  // stage A: mag = 45*qm + rm, so phase = qm*2^22 + floor((rm*2^22+22)/45)
  logic [AngleW:0]      mag;
  logic                 neg;
  logic [2*AngleW+1:0]  prod;
  logic [11:0]          qm;
  logic [5:0]           rm;
  logic [11:0]          qm_r;
  logic [5:0]           rm_r;
  logic                 neg_r;
  logic [PhaseW-1:0]    pm;
  logic [PhaseW-1:0]    phase;
  logic                 flip;
  logic [PhaseW-1:0]    phase_f;

  assign neg  = angle[AngleW-1];
  assign mag  = neg ? (AngleW+1)'(-$signed({angle[AngleW-1], angle})) : {1'b0, angle};
  assign prod = mag * Recip45;
  assign qm   = 12'(prod >> 22);
  assign rm   = 6'(mag - 17'(qm) * 17'd45);

  always_ff @(posedge clk) begin
    if (en) begin
      qm_r  <= qm;
      rm_r  <= rm;
      neg_r <= neg;
    end
  end

  assign pm      = PhaseW'({qm_r, 22'd0}) + rem_phase(rm_r);
  assign phase   = neg_r ? (PhaseW'(0) - pm) : pm;
  assign flip    = phase[PhaseW-1] ^ phase[PhaseW-2];
  assign phase_f = flip ? (phase + 32'h8000_0000) : phase;

  logic signed [CordW-1:0]  xs [0:NST];
  logic signed [CordW-1:0]  ys [0:NST];
  logic signed [PhaseW:0]   zs [0:NST];
  logic                     fs [0:NST];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CordicGain;
      ys[0] <= '0;
      zs[0] <= {phase_f[PhaseW-1], phase_f};
      fs[0] <= flip;
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_st
    logic signed [CordW-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        fs[i+1] <= fs[i];
        if (!zs[i][PhaseW]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + atan_turn(i);
        end
      end
    end
  end

  logic signed [CordW-1:0] xr, yr;
  trig_t c_t, s_t;
  assign xr  = (xs[NST] + CordW'(16384)) >>> 15;
  assign yr  = (ys[NST] + CordW'(16384)) >>> 15;
  assign c_t = fs[NST] ? -xr[CompW:0] : xr[CompW:0];
  assign s_t = fs[NST] ? -yr[CompW:0] : yr[CompW:0];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q15 <= c_t;
      sin_q15 <= s_t;
    end
  end

endmodule

### rtl/core/e2q_merge.sv
// Merge stage: pairwise then triple products, sums, rounding and saturation.
// Depends on e2q_pkg.
module e2q_merge (
  input  logic                              clk,
  input  logic                              en,
  input  e2q_pkg::trig_t                    s1, c1, s2, c2, s3, c3,
  output logic signed [e2q_pkg::CompW-1:0]  qw, qx, qy, qz
);
  import e2q_pkg::*;

  logic signed [2*CompW+1:0] cc, ss, sc, cs;
  trig_t s3r, c3r;
  always_ff @(posedge clk) begin
    if (en) begin
      cc <= c1 * c2; ss <= s1 * s2; sc <= s1 * c2; cs <= c1 * s2;
      s3r <= s3; c3r <= c3;
    end
  end

  localparam int PW = 3*CompW+4;
  logic signed [PW-1:0] p_ccc, p_sss, p_scc, p_css, p_csc, p_scs, p_ccs, p_ssc;
  always_ff @(posedge clk) begin
    if (en) begin
      p_ccc <= PW'(cc) * PW'(c3r); p_sss <= PW'(ss) * PW'(s3r);
      p_scc <= PW'(sc) * PW'(c3r); p_css <= PW'(cs) * PW'(s3r);
      p_csc <= PW'(cs) * PW'(c3r); p_scs <= PW'(sc) * PW'(s3r);
      p_ccs <= PW'(cc) * PW'(s3r); p_ssc <= PW'(ss) * PW'(c3r);
    end
  end

  function automatic logic signed [CompW-1:0] fin(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    begin
      r = (v + PW'(1 << 29)) >>> 30;
      if (r > PW'(32767)) return 16'sh7fff;
      else if (r < -PW'(32768)) return 16'sh8000;
      else return r[CompW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      qw <= fin(p_ccc - p_sss);
      qx <= fin(p_scc + p_css);
      qy <= fin(p_csc - p_scs);
      qz <= fin(p_ccs + p_ssc);
    end
  end

endmodule

### rtl/core/euler_to_quaternion_unit.sv
// Euler angles (x-y-z, 1/64 degree) to Q1.15 rotation quaternion.
// Throughput one transaction per cycle while the output is not stalled; three CORDIC lanes run in parallel.
// The pipeline advances whenever the output is free or being taken.
// Reset (rst, synchronous) clears only the valid bits of the pipeline.
module euler_to_quaternion_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // angle_x, angle_y, angle_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  localparam int NST = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int LAT = NST + 6;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  trig_t s1, c1, s2, c2, s3, c3;
  e2q_lane #(.STAGES(CORDIC_STAGES)) u_lx (.clk, .en, .angle(s_axis_tdata[15:0]),
    .sin_q15(s1), .cos_q15(c1));
  e2q_lane #(.STAGES(CORDIC_STAGES)) u_ly (.clk, .en, .angle(s_axis_tdata[31:16]),
    .sin_q15(s2), .cos_q15(c2));
  e2q_lane #(.STAGES(CORDIC_STAGES)) u_lz (.clk, .en, .angle(s_axis_tdata[47:32]),
    .sin_q15(s3), .cos_q15(c3));

  logic signed [CompW-1:0] qw, qx, qy, qz;
  e2q_merge u_mrg (.clk, .en, .s1, .c1, .s2, .c2, .s3, .c3, .qw, .qx, .qy, .qz);

  assign m_axis_tdata = {qz, qy, qx, qw};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while stalled");
  a_adv: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |=> vld[0] == $past(s_axis_tvalid))
    else $error("pipeline valid lost");

endmodule
